// ----- src/atl_pkg.sv -----
// Package for the associative TLB: defaults, operation codes, state and command types.
package atl_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int PAGE_BITS_DEF = 12;
    localparam int VA_BITS_DEF   = 39;
    localparam int PA_BITS_DEF   = 56;
    localparam int ASID_W        = 16;
    localparam int KIND_W        = 2;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
        logic load_out;
    } t_dp_cmd;

endpackage

// ----- src/atl_if.sv -----
// Request and response channel interfaces of the associative TLB.
interface atl_req_if #(
    parameter int VA_BITS = atl_pkg::VA_BITS_DEF,
    parameter int PA_BITS = atl_pkg::PA_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [atl_pkg::KIND_W-1:0]  kind;
    logic [VA_BITS-1:0]          virt_addr;
    logic [atl_pkg::ASID_W-1:0]  asid;
    logic [PA_BITS-1:0]          phys_in;

    modport source (output valid, kind, virt_addr, asid, phys_in, input ready);
    modport sink   (input valid, kind, virt_addr, asid, phys_in, output ready);
endinterface

interface atl_rsp_if #(
    parameter int PA_BITS = atl_pkg::PA_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic               hit;
    logic [PA_BITS-1:0] phys_out;

    modport source (output valid, hit, phys_out, input ready);
    modport sink   (input valid, hit, phys_out, output ready);
endinterface

// ----- src/assoc_tlb_lru_unit.sv -----
// Fully associative TLB with least recently used replacement.
// Sequence: the request is captured, the tags are compared, the ranks and the RAM are updated
// with the physical page read registered, and the result register loads once its slot is free.
// A new request is accepted only after the controller has loaded the result and gone back
// to idle, so only one item is in flight at a time.
// Reset (synchronous, active low) clears all valid bits and sets the ranks to index order;
// the tag and physical page stores are not cleared.
module assoc_tlb_lru_unit #(
    parameter int ENTRIES   = atl_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = atl_pkg::PAGE_BITS_DEF,
    parameter int VA_BITS   = atl_pkg::VA_BITS_DEF,
    parameter int PA_BITS   = atl_pkg::PA_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    atl_req_if.sink    i_req,
    atl_rsp_if.source  o_rsp
);

    atl_pkg::t_dp_cmd cmd;

    atl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    atl_dp #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS),
        .VA_BITS   (VA_BITS),
        .PA_BITS   (PA_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_req.kind),
        .i_virt_addr (i_req.virt_addr),
        .i_asid      (i_req.asid),
        .i_phys_in   (i_req.phys_in),
        .o_hit       (o_rsp.hit),
        .o_phys_out  (o_rsp.phys_out)
    );

endmodule

// ----- src/atl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module atl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/atl_ctrl.sv -----
// Controller state machine that sequences capture, compare, update and result load.
module atl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output atl_pkg::t_dp_cmd o_cmd
);

    atl_pkg::t_state r_state;
    atl_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    // The result register may be refilled in the cycle its transfer completes.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            atl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = atl_pkg::S_CMP;
                end
            end
            atl_pkg::S_CMP: begin
                n_state = atl_pkg::S_UPD;
            end
            atl_pkg::S_UPD: begin
                n_state = atl_pkg::S_DONE;
            end
            atl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = atl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = atl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            atl_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            atl_pkg::S_CMP: begin
                o_cmd.compare = 1'b1;
            end
            atl_pkg::S_UPD: begin
                o_cmd.update = 1'b1;
            end
            atl_pkg::S_DONE: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- src/atl_dp.sv -----
// Datapath: entry tags, valid bits, recency ranks, physical page RAM and result register.
module atl_dp #(
    parameter int ENTRIES   = atl_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = atl_pkg::PAGE_BITS_DEF,
    parameter int VA_BITS   = atl_pkg::VA_BITS_DEF,
    parameter int PA_BITS   = atl_pkg::PA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  atl_pkg::t_dp_cmd            i_cmd,
    input  logic [atl_pkg::KIND_W-1:0]  i_kind,
    input  logic [VA_BITS-1:0]          i_virt_addr,
    input  logic [atl_pkg::ASID_W-1:0]  i_asid,
    input  logic [PA_BITS-1:0]          i_phys_in,
    output logic                        o_hit,
    output logic [PA_BITS-1:0]          o_phys_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int VPN_W = VA_BITS - PAGE_BITS;
    localparam int PPN_W = PA_BITS - PAGE_BITS;
    localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(ENTRIES - 1);

    // Captured item.
    logic [atl_pkg::KIND_W-1:0] r_kind;
    logic [VPN_W-1:0]           r_vpn;
    logic [PAGE_BITS-1:0]       r_offset;
    logic [atl_pkg::ASID_W-1:0] r_asid;
    logic [PPN_W-1:0]           r_ppn;

    // Entry state.
    logic [ENTRIES-1:0]         r_valid;
    logic [VPN_W-1:0]           r_tag_vpn  [ENTRIES];
    logic [atl_pkg::ASID_W-1:0] r_tag_asid [ENTRIES];
    logic [IDX_W-1:0]           r_rank     [ENTRIES];

    // Compare results.
    logic                       r_hit;
    logic [IDX_W-1:0]           r_idx;
    logic [IDX_W-1:0]           r_slot;

    // Result register.
    logic                       r_out_hit;
    logic [PA_BITS-1:0]         r_out_phys;

    logic [ENTRIES-1:0]         match;
    logic [IDX_W-1:0]           hit_idx;
    logic [IDX_W-1:0]           free_idx;
    logic [IDX_W-1:0]           lru_idx;
    logic                       any_free;
    logic                       is_lookup;
    logic                       is_insert;
    logic                       do_touch;
    logic                       do_fill;
    logic [IDX_W-1:0]           touch_idx;
    logic [IDX_W-1:0]           touch_rank;
    logic [PPN_W-1:0]           ram_rd_data;

    assign is_lookup = (r_kind == atl_pkg::KIND_LOOKUP);
    assign is_insert = (r_kind == atl_pkg::KIND_INSERT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_vpn    <= i_virt_addr[VA_BITS-1:PAGE_BITS];
            r_offset <= i_virt_addr[PAGE_BITS-1:0];
            r_asid   <= i_asid;
            r_ppn    <= i_phys_in[PA_BITS-1:PAGE_BITS];
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag_vpn[i] == r_vpn) && (r_tag_asid[i] == r_asid);
        end
    end

    // Highest matching entry wins; lowest invalid entry is filled first.
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (r_rank[i] == '0) begin
                lru_idx = IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_free = !(&r_valid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_hit  <= |match;
            r_idx  <= hit_idx;
            r_slot <= any_free ? free_idx : lru_idx;
        end
    end

    assign do_fill   = i_cmd.update && is_insert && !r_hit;
    assign do_touch  = (i_cmd.update && is_lookup && r_hit) || do_fill;
    assign touch_idx = is_lookup ? r_idx : r_slot;

    always_comb begin
        touch_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (touch_idx == IDX_W'(i)) begin
                touch_rank = touch_rank | r_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= IDX_W'(i);
            end
        end else begin
            if (i_cmd.update && (r_kind == atl_pkg::KIND_FLUSH)) begin
                r_valid <= '0;
            end else if (do_fill) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (do_touch) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (touch_idx == IDX_W'(i)) begin
                        r_rank[i] <= RANK_TOP;
                    end else if (r_rank[i] > touch_rank) begin
                        r_rank[i] <= r_rank[i] - IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            r_tag_vpn[r_slot]  <= r_vpn;
            r_tag_asid[r_slot] <= r_asid;
        end
    end

    atl_ram #(
        .WIDTH (PPN_W),
        .DEPTH (ENTRIES)
    ) u_ppn_ram (
        .i_clk     (i_clk),
        .i_wr_en   (do_fill),
        .i_wr_addr (r_slot),
        .i_wr_data (r_ppn),
        .i_rd_en   (i_cmd.update && is_lookup && r_hit),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit  <= is_lookup && r_hit;
            r_out_phys <= (is_lookup && r_hit) ? {ram_rd_data, r_offset} : '0;
        end
    end

    assign o_hit      = r_out_hit;
    assign o_phys_out = r_out_phys;

endmodule

// ----- src/atl_checker.sv -----
// Port-level checker for the associative TLB and its bind to the top level.
module atl_checker #(
    parameter int PA_BITS = atl_pkg::PA_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_rsp_hit,
    input logic [PA_BITS-1:0] i_rsp_phys
);

    logic req_xfer;
    assign req_xfer = i_req_valid && i_req_ready;

    // Only one item is in flight, so the request side closes after a transfer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req_ready)
        else $error("request accepted while an item is in flight");

    // With the result slot empty, the result must appear after the transfer without any stall.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer && !i_rsp_valid |-> ##4 i_rsp_valid)
        else $error("result did not appear four cycles after the transfer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_hit |-> (i_rsp_phys == '0))
        else $error("address on a result without a hit");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_phys) && $stable(i_rsp_hit))
        else $error("stalled result changed");

endmodule

bind assoc_tlb_lru_unit atl_checker #(
    .PA_BITS (PA_BITS)
) u_atl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_hit   (o_rsp.hit),
    .i_rsp_phys  (o_rsp.phys_out)
);

// ----- dv/assoc_tlb_lru_unit_tb.sv -----
// Self-checking testbench for the associative TLB with LRU replacement.
module assoc_tlb_lru_unit_tb;

    localparam int ENTRIES    = atl_pkg::ENTRIES_DEF;
    localparam int PAGE_BITS  = atl_pkg::PAGE_BITS_DEF;
    localparam int VA_BITS    = atl_pkg::VA_BITS_DEF;
    localparam int PA_BITS    = atl_pkg::PA_BITS_DEF;
    localparam int ASID_W     = atl_pkg::ASID_W;
    localparam int KIND_W     = atl_pkg::KIND_W;
    localparam int VPN_W      = VA_BITS - PAGE_BITS;
    localparam int PPN_W      = PA_BITS - PAGE_BITS;
    localparam int RANK_W     = $clog2(ENTRIES);
    localparam int POOL       = 24;
    localparam int LONG_HOLD  = 150;
    localparam int MAX_CYCLES = 500000;

    typedef logic [RANK_W-1:0] t_rank;

    typedef struct packed {
        logic               hit;
        logic [PA_BITS-1:0] phys;
    } t_xlate;

    // Shadow copy of the TLB contents and recency order; predicts every response.
    class tlb_shadow;
        logic               ent_valid[ENTRIES];
        logic [VPN_W-1:0]   ent_vpage[ENTRIES];
        logic [ASID_W-1:0]  ent_asid[ENTRIES];
        logic [PPN_W-1:0]   ent_ppage[ENTRIES];
        t_rank              lru_rank[ENTRIES];
        t_xlate             expected_xlate_q[$];
        int errors;
        int n_lookup, n_hit, n_fill, n_evict, n_flush, n_other, n_checked;

        function new();
            foreach (ent_valid[i]) begin
                ent_valid[i] = 1'b0;
                lru_rank[i]  = t_rank'(i);
            end
        endfunction

        function void touch(int idx);
            t_rank r;
            r = lru_rank[idx];
            foreach (lru_rank[i])
                if (lru_rank[i] > r) lru_rank[i]--;
            lru_rank[idx] = t_rank'(ENTRIES - 1);
        endfunction

        function int find(logic [VPN_W-1:0] vp, logic [ASID_W-1:0] as);
            int found;
            found = -1;
            foreach (ent_valid[i])
                if (ent_valid[i] && ent_vpage[i] == vp && ent_asid[i] == as) found = i;
            return found;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [VA_BITS-1:0] va,
                                   logic [ASID_W-1:0] as, logic [PA_BITS-1:0] pa);
            t_xlate           res;
            logic [VPN_W-1:0] vp;
            int               idx;
            int               slot;
            res = '0;
            vp  = va[VA_BITS-1:PAGE_BITS];
            case (kind)
                atl_pkg::KIND_LOOKUP: begin
                    n_lookup++;
                    idx = find(vp, as);
                    if (idx >= 0) begin
                        n_hit++;
                        touch(idx);
                        res.hit  = 1'b1;
                        res.phys = {ent_ppage[idx], va[PAGE_BITS-1:0]};
                    end
                end
                atl_pkg::KIND_INSERT: begin
                    if (find(vp, as) < 0) begin
                        slot = -1;
                        for (int i = 0; i < ENTRIES; i++)
                            if (!ent_valid[i] && slot < 0) slot = i;
                        // All entries in use: the one with the lowest rank goes.
                        if (slot < 0) begin
                            slot = 0;
                            for (int i = 1; i < ENTRIES; i++)
                                if (lru_rank[i] < lru_rank[slot]) slot = i;
                            n_evict++;
                        end
                        ent_valid[slot] = 1'b1;
                        ent_vpage[slot] = vp;
                        ent_asid[slot]  = as;
                        ent_ppage[slot] = pa[PA_BITS-1:PAGE_BITS];
                        touch(slot);
                        n_fill++;
                    end
                end
                atl_pkg::KIND_FLUSH: begin
                    n_flush++;
                    foreach (ent_valid[i]) ent_valid[i] = 1'b0;
                end
                default: n_other++;
            endcase
            expected_xlate_q = {expected_xlate_q, res};
        endfunction

        function void check_response(logic hit, logic [PA_BITS-1:0] phys);
            t_xlate want;
            if (expected_xlate_q.size() == 0) begin
                $display("%0t: response with nothing expected, hit=%0b phys_out=%h",
                         $time, hit, phys);
                errors++;
                return;
            end
            want = expected_xlate_q[0];
            expected_xlate_q.delete(0);
            n_checked++;
            if (hit !== want.hit) begin
                $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
                errors++;
            end
            if (phys !== want.phys) begin
                $display("%0t: phys_out mismatch, expected %h, actual %h",
                         $time, want.phys, phys);
                errors++;
            end
        endfunction

        function int pending();
            return expected_xlate_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    atl_req_if #(.VA_BITS(VA_BITS), .PA_BITS(PA_BITS)) req_if ();
    atl_rsp_if #(.PA_BITS(PA_BITS)) rsp_if ();

    assoc_tlb_lru_unit #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS),
        .VA_BITS   (VA_BITS),
        .PA_BITS   (PA_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    tlb_shadow        shadow;
    int               src_idle_pct  = 0;
    int               snk_stall_pct = 0;
    bit               long_hold_req = 1'b0;
    int               hold_left     = 0;
    logic [VPN_W-1:0]  pool_vpage[POOL];
    logic [ASID_W-1:0] pool_asid[POOL];

    always #10 i_clk = ~i_clk;

    // Response side: random stalls, plus one long hold-off counted here.
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            shadow.check_response(rsp_if.hit, rsp_if.phys_out);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void refresh_pool(int idx);
        logic [63:0] r;
        r = rand64();
        // Some pages are shared between address spaces to exercise the ASID compare.
        if ($urandom_range(3) == 0)
            pool_vpage[idx] = pool_vpage[$urandom_range(POOL - 1)];
        else
            pool_vpage[idx] = r[VPN_W-1:0];
        pool_asid[idx] = r[63:64-ASID_W];
    endfunction

    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [VA_BITS-1:0] va,
                            input logic [ASID_W-1:0] as, input logic [PA_BITS-1:0] pa);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.kind      <= kind;
        req_if.virt_addr <= va;
        req_if.asid      <= as;
        req_if.phys_in   <= pa;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.note_request(kind, va, as, pa);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [63:0]        r;
        logic [63:0]        p;
        logic [VA_BITS-1:0] va;
        int                 pick;
        int                 roll;
        r = rand64();
        p = rand64();
        if ($urandom_range(99) < 4) refresh_pool($urandom_range(POOL - 1));
        pick = $urandom_range(POOL - 1);
        roll = $urandom_range(99);
        va   = {pool_vpage[pick], r[PAGE_BITS-1:0]};
        if (roll < 55)
            send_req(atl_pkg::KIND_LOOKUP, va, pool_asid[pick], p[PA_BITS-1:0]);
        else if (roll < 90)
            send_req(atl_pkg::KIND_INSERT, va, pool_asid[pick], p[PA_BITS-1:0]);
        else if (roll < 93)
            send_req(atl_pkg::KIND_FLUSH, r[VA_BITS-1:0], r[63:64-ASID_W], p[PA_BITS-1:0]);
        else if (roll < 95)
            send_req(~atl_pkg::KIND_LOOKUP, r[VA_BITS-1:0], r[63:64-ASID_W],
                     p[PA_BITS-1:0]);
        else
            send_req(atl_pkg::KIND_LOOKUP, r[VA_BITS-1:0], r[63:64-ASID_W],
                     p[PA_BITS-1:0]);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (count) send_random();
        drain();
    endtask

    initial begin
        #(MAX_CYCLES * 20);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [VA_BITS-1:0] va_ones;
        logic [PA_BITS-1:0] pa_ones;
        logic [VA_BITS-1:0] va_page;
        shadow           = new();
        va_ones          = '1;
        pa_ones          = '1;
        req_if.valid     = 1'b0;
        req_if.kind      = atl_pkg::KIND_LOOKUP;
        req_if.virt_addr = '0;
        req_if.asid      = '0;
        req_if.phys_in   = '0;
        rsp_if.ready     = 1'b0;
        for (int i = 0; i < POOL; i++) pool_vpage[i] = '0;
        for (int i = 0; i < POOL; i++) refresh_pool(i);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, unused kind, extreme fields, duplicate insert,
        // fill to capacity, eviction of the least recent entry, flush.
        send_req(atl_pkg::KIND_LOOKUP, va_ones, '1, pa_ones);
        send_req(~atl_pkg::KIND_LOOKUP, va_ones, '1, pa_ones);
        send_req(atl_pkg::KIND_INSERT, '0, '0, '0);
        send_req(atl_pkg::KIND_LOOKUP, va_ones >> (VA_BITS - PAGE_BITS), '0, '0);
        send_req(atl_pkg::KIND_INSERT, va_ones, '1, pa_ones);
        send_req(atl_pkg::KIND_LOOKUP, va_ones, '1, '0);
        send_req(atl_pkg::KIND_LOOKUP, va_ones, 16'hfffe, '0);
        send_req(atl_pkg::KIND_INSERT, va_ones, '1, '0);
        send_req(atl_pkg::KIND_LOOKUP, va_ones, '1, '0);
        for (int i = 1; i <= ENTRIES - 1; i++) begin
            va_page = VA_BITS'(i) << PAGE_BITS;
            send_req(atl_pkg::KIND_INSERT, va_page, ASID_W'(i),
                     PA_BITS'(i) << (PAGE_BITS + 8));
        end
        send_req(atl_pkg::KIND_LOOKUP, '0, '0, '0);
        send_req(atl_pkg::KIND_FLUSH, '0, '0, '0);
        send_req(atl_pkg::KIND_LOOKUP, va_ones, '1, '0);
        drain();

        run_phase(0, 0, 300);
        run_phase(88, 0, 150);
        run_phase(0, 88, 150);
        run_phase(9, 9, 300);
        // Responses held off for a long stretch while requests keep coming.
        long_hold_req = 1'b1;
        run_phase(0, 0, 100);

        repeat (12) @(negedge i_clk);
        $display("Covered %0d lookups with %0d hits, %0d new entries with %0d evictions,",
                 shadow.n_lookup, shadow.n_hit, shadow.n_fill, shadow.n_evict);
        $display("%0d flushes and %0d unused-kind items; %0d responses checked.",
                 shadow.n_flush, shadow.n_other, shadow.n_checked);
        if (shadow.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
